// File: hw/rtl/aminv_pkg.sv
// Shared types and fixed widths for the affine matrix inverse.
package aminv_pkg;

  localparam int unsigned ElemW     = 32;   // input and output element width
  localparam int unsigned ProdW     = 64;   // 32x32 product
  localparam int unsigned CofW      = 65;   // cofactor, difference of two products
  localparam int unsigned PartW     = 65;   // 32x33 partial product
  localparam int unsigned SumW      = 99;   // determinant and translation dot products
  localparam int unsigned NegW      = SumW + 1;
  localparam int unsigned QuoW      = 32;   // quotient bits resolved by the divider
  localparam int unsigned RemW      = SumW + QuoW;
  localparam int unsigned Lanes     = 12;
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = 3;
  localparam int unsigned FifoCntW  = 4;

  typedef struct packed {
    logic signed [ElemW-1:0] a00;
    logic signed [ElemW-1:0] a01;
    logic signed [ElemW-1:0] a02;
    logic signed [ElemW-1:0] a10;
    logic signed [ElemW-1:0] a11;
    logic signed [ElemW-1:0] a12;
    logic signed [ElemW-1:0] a20;
    logic signed [ElemW-1:0] a21;
    logic signed [ElemW-1:0] a22;
    logic signed [ElemW-1:0] tx;
    logic signed [ElemW-1:0] ty;
    logic signed [ElemW-1:0] tz;
  } in_item_t;

  typedef struct packed {
    logic signed [ElemW-1:0] i00;
    logic signed [ElemW-1:0] i01;
    logic signed [ElemW-1:0] i02;
    logic signed [ElemW-1:0] i10;
    logic signed [ElemW-1:0] i11;
    logic signed [ElemW-1:0] i12;
    logic signed [ElemW-1:0] i20;
    logic signed [ElemW-1:0] i21;
    logic signed [ElemW-1:0] i22;
    logic signed [ElemW-1:0] ux;
    logic signed [ElemW-1:0] uy;
    logic signed [ElemW-1:0] uz;
  } out_item_t;

  // cof[k*3+j] is element j of adjugate column k
  typedef struct packed {
    logic [8:0][CofW-1:0] cof;
    logic [2:0][SumW-1:0] acc;
    logic [SumW-1:0]      det;
  } work_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [FifoCntW-1:0] count;
  } fifo_stat_t;

endpackage

// File: hw/rtl/aminv_front.sv
// Front end: cofactors, determinant and translation dot products, exact.
module aminv_front import aminv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  in_item_t   item_i,
  output logic       push_o,
  output work_t      work_o,
  output logic [1:0] inflight_o
);

  logic signed [ElemW-1:0] row [3][3];
  logic signed [ElemW-1:0] tv  [3];

  logic signed [ProdW-1:0] p1_q [3][3][2];
  logic signed [ElemW-1:0] r01_q [3];
  logic signed [ElemW-1:0] t1_q  [3];

  logic signed [CofW-1:0]  cof2_q [3][3];
  logic signed [ElemW-1:0] r02_q [3];
  logic signed [ElemW-1:0] t2_q  [3];

  logic signed [CofW-1:0]  cof3_q [3][3];
  logic signed [PartW-1:0] dlo_q [3];
  logic signed [PartW-1:0] dhi_q [3];
  logic signed [PartW-1:0] alo_q [3][3];
  logic signed [PartW-1:0] ahi_q [3][3];

  logic v1_q, v2_q, v3_q;

  function automatic logic signed [SumW-1:0] join_pp(input logic signed [PartW-1:0] hi,
                                                     input logic signed [PartW-1:0] lo);
    logic signed [SumW-1:0] h;
    logic signed [SumW-1:0] l;
    h = SumW'(hi);
    l = SumW'(lo);
    return (h <<< 32) + l;
  endfunction

  always_comb begin
    row[0][0] = item_i.a00; row[0][1] = item_i.a01; row[0][2] = item_i.a02;
    row[1][0] = item_i.a10; row[1][1] = item_i.a11; row[1][2] = item_i.a12;
    row[2][0] = item_i.a20; row[2][1] = item_i.a21; row[2][2] = item_i.a22;
    tv[0] = item_i.tx; tv[1] = item_i.ty; tv[2] = item_i.tz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // column c of the adjugate is row[c+1] x row[c+2]
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      for (int e = 0; e < 3; e++) begin
        p1_q[c][e][0] <= row[(c+1)%3][(e+1)%3] * row[(c+2)%3][(e+2)%3];
        p1_q[c][e][1] <= row[(c+1)%3][(e+2)%3] * row[(c+2)%3][(e+1)%3];
        cof2_q[c][e]  <= CofW'(p1_q[c][e][0]) - CofW'(p1_q[c][e][1]);
        cof3_q[c][e]  <= cof2_q[c][e];
      end
      r01_q[c] <= row[0][c];
      t1_q[c]  <= tv[c];
      r02_q[c] <= r01_q[c];
      t2_q[c]  <= t1_q[c];
      // split 65-bit cofactor into signed high and unsigned low halves
      dlo_q[c] <= r02_q[c] * $signed({1'b0, cof2_q[0][c][31:0]});
      dhi_q[c] <= r02_q[c] * $signed(cof2_q[0][c][CofW-1:32]);
      for (int j = 0; j < 3; j++) begin
        alo_q[j][c] <= t2_q[c] * $signed({1'b0, cof2_q[c][j][31:0]});
        ahi_q[j][c] <= t2_q[c] * $signed(cof2_q[c][j][CofW-1:32]);
      end
    end
  end

  always_comb begin
    work_o.det = join_pp(dhi_q[0], dlo_q[0]) + join_pp(dhi_q[1], dlo_q[1])
               + join_pp(dhi_q[2], dlo_q[2]);
    for (int j = 0; j < 3; j++) begin
      work_o.acc[j] = join_pp(ahi_q[j][0], alo_q[j][0]) + join_pp(ahi_q[j][1], alo_q[j][1])
                    + join_pp(ahi_q[j][2], alo_q[j][2]);
      for (int k = 0; k < 3; k++) begin
        work_o.cof[k*3+j] = cof3_q[k][j];
      end
    end
  end

  assign push_o     = v3_q;
  assign inflight_o = 2'({1'b0, v1_q} + {1'b0, v2_q} + {1'b0, v3_q});

endmodule

// File: hw/rtl/aminv_fifo.sv
// Queue of work items between front end and divider back end.
module aminv_fifo import aminv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  work_t      data_i,
  input  logic       pop_i,
  output work_t      data_o,
  output fifo_stat_t stat_o
);

  work_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FifoCntW'(FifoDepth));

endmodule

// File: hw/rtl/aminv_back.sv
// Back end: twelve pipelined restoring dividers with rounding and saturation.
module aminv_back import aminv_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  work_t     work_i,
  output logic      strobe_o,
  output out_item_t res_o
);

  logic [RemW-1:0]  r_q   [QuoW+1][Lanes];
  logic [QuoW-1:0]  q_q   [QuoW+1][Lanes];
  logic             neg_q [QuoW+1][Lanes];
  logic             ovf_q [QuoW+1][Lanes];
  logic [SumW-1:0]  d_q   [QuoW+1];
  logic             zero_q[QuoW+1];
  logic [QuoW:0]    v_q;

  logic [RemW-1:0]  r_d   [QuoW+1][Lanes];
  logic [QuoW-1:0]  q_d   [QuoW+1][Lanes];
  logic [RemW-1:0]  n_d   [Lanes];
  logic             neg_d [Lanes];
  logic             ovf_d [Lanes];
  logic [SumW-1:0]  d_d;

  logic [ElemW-1:0] res_d [Lanes];
  logic [ElemW-1:0] res_q [Lanes];
  logic             strobe_q;

  // operand set-up: magnitudes, result sign, numerator scaling, overflow
  always_comb begin
    logic signed [NegW-1:0] num;
    logic [NegW-1:0]        mag;
    logic [RemW-1:0]        n;
    d_d = work_i.det[SumW-1] ? SumW'(-work_i.det) : work_i.det;
    for (int l = 0; l < Lanes; l++) begin
      if (l < 9) begin
        num = NegW'($signed(work_i.cof[(l%3)*3 + l/3]));
      end else begin
        num = -NegW'($signed(work_i.acc[l-9]));
      end
      mag      = num[NegW-1] ? NegW'(-num) : NegW'(num);
      n        = (l < 9) ? (RemW'(mag) << (2*FracBits)) : (RemW'(mag) << FracBits);
      neg_d[l] = num[NegW-1] ^ work_i.det[SumW-1];
      ovf_d[l] = n >= {d_d, QuoW'(0)};
      n_d[l]   = n;
    end
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    logic [RemW-1:0] dsh;
    logic            ge;
    for (int l = 0; l < Lanes; l++) begin
      r_d[0][l] = n_d[l];
      q_d[0][l] = '0;
    end
    for (int s = 0; s < QuoW; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        dsh         = RemW'(d_q[s]) << (QuoW-1-s);
        ge          = r_q[s][l] >= dsh;
        r_d[s+1][l] = ge ? r_q[s][l] - dsh : r_q[s][l];
        q_d[s+1][l] = {q_q[s][l][QuoW-2:0], ge};
      end
    end
  end

  // round half away from zero, then saturate
  always_comb begin
    logic [SumW-1:0] rem;
    logic            rnd;
    logic [QuoW:0]   qr;
    for (int l = 0; l < Lanes; l++) begin
      rem = r_q[QuoW][l][SumW-1:0];
      rnd = {rem, 1'b0} >= {1'b0, d_q[QuoW]};
      qr  = {1'b0, q_q[QuoW][l]} + (QuoW+1)'(rnd);
      if (zero_q[QuoW]) begin
        res_d[l] = '0;
      end else if (neg_q[QuoW][l]) begin
        if (ovf_q[QuoW][l] || qr[QuoW:QuoW-1] != 2'b00) res_d[l] = {1'b1, {(ElemW-1){1'b0}}};
        else res_d[l] = ElemW'(-qr);
      end else begin
        if (ovf_q[QuoW][l] || qr[QuoW:QuoW-1] != 2'b00) res_d[l] = {1'b0, {(ElemW-1){1'b1}}};
        else res_d[l] = qr[ElemW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      v_q      <= {v_q[QuoW-1:0], valid_i};
      strobe_q <= v_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0]    <= d_d;
    zero_q[0] <= (work_i.det == '0);
    for (int l = 0; l < Lanes; l++) begin
      r_q[0][l]   <= r_d[0][l];
      q_q[0][l]   <= q_d[0][l];
      neg_q[0][l] <= neg_d[l];
      ovf_q[0][l] <= ovf_d[l];
    end
    for (int s = 0; s < QuoW; s++) begin
      d_q[s+1]    <= d_q[s];
      zero_q[s+1] <= zero_q[s];
      for (int l = 0; l < Lanes; l++) begin
        r_q[s+1][l]   <= r_d[s+1][l];
        q_q[s+1][l]   <= q_d[s+1][l];
        neg_q[s+1][l] <= neg_q[s][l];
        ovf_q[s+1][l] <= ovf_q[s][l];
      end
    end
    for (int l = 0; l < Lanes; l++) begin
      res_q[l] <= res_d[l];
    end
  end

  always_comb begin
    res_o.i00 = res_q[0];  res_o.i01 = res_q[1];  res_o.i02 = res_q[2];
    res_o.i10 = res_q[3];  res_o.i11 = res_q[4];  res_o.i12 = res_q[5];
    res_o.i20 = res_q[6];  res_o.i21 = res_q[7];  res_o.i22 = res_q[8];
    res_o.ux  = res_q[9];  res_o.uy  = res_q[10]; res_o.uz  = res_q[11];
  end

  assign strobe_o = strobe_q;

endmodule

// File: hw/rtl/affine_matrix_inverse.sv
// Affine 4x4 transform inverse, top level.
//
// Input: the 3x3 linear part and translation, signed fixed point with
// FRAC_BITS fraction bits, taken on item_i at a clock edge where start is
// high and busy is low. Output: the inverse linear part and the inverse
// translation -A^-1 t on res_o, valid for exactly one cycle with strobe_o.
// Results are rounded to nearest (ties away from zero) and saturate to the
// 32-bit range; a singular matrix gives all zeros.
// One item is accepted every cycle while busy is low; results return in
// order. The front end registers products, cofactors, then determinant
// and translation partials; the queue holds work items in its memory, and
// the back end runs twelve dividers pipelined at one quotient bit per stage
// (32 stages) plus set-up and output registers. busy rises only if the
// queue could not take every item already in the front end; with the back
// end draining every cycle it stays low. The receiver cannot stall. Reset
// empties pipeline and queue, dropping items in flight; none is invented.
module affine_matrix_inverse import aminv_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_item_t  item_i,
  output logic      busy,
  output logic      strobe_o,
  output out_item_t res_o
);

  localparam int unsigned Latency = 38;

  logic       accept;
  logic       push;
  logic       pop;
  logic [1:0] inflight;
  work_t      work_front;
  work_t      work_back;
  fifo_stat_t fifo_stat;
  logic [FifoCntW:0] occupancy;

  assign accept    = start && !busy;
  assign occupancy = (FifoCntW+1)'(inflight) + (FifoCntW+1)'(fifo_stat.count);
  assign busy      = occupancy >= (FifoCntW+1)'(FifoDepth);
  assign pop       = !fifo_stat.empty;

  aminv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .item_i    (item_i),
    .push_o    (push),
    .work_o    (work_front),
    .inflight_o(inflight)
  );

  aminv_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(work_front),
    .pop_i (pop),
    .data_o(work_back),
    .stat_o(fifo_stat)
  );

  aminv_back #(
    .FracBits(FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pop),
    .work_i  (work_back),
    .strobe_o(strobe_o),
    .res_o   (res_o)
  );

`ifndef ASSERT_OFF
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_stat.full && !pop))
    else $error("queue written while full");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency strobe_o)
    else $error("accepted item produced no result");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, Latency))
    else $error("result without a matching transfer");
`endif

endmodule

// File: verif/affine_matrix_inverse_tb.sv
// Self-checking testbench for the affine matrix inverse: random and corner matrices.
module affine_matrix_inverse_tb;
  import aminv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Frac = 16;
  localparam int unsigned IdleLimit = 2000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  in_item_t  item_i = '0;
  logic      busy;
  logic      strobe_o;
  out_item_t res_o;

  in_item_t  pending_q[$];
  out_item_t inverse_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        gap_pct = 0;
  bit        hold_off = 1'b0;
  bit        stim_done = 1'b0;
  bit        took = 1'b0;

  affine_matrix_inverse #(.FRAC_BITS(Frac)) dut (
    .clk_i, .rst_ni, .start, .item_i, .busy, .strobe_o, .res_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // round(num * 2^sh / den), ties away from zero, saturated to 32 bits
  function automatic logic signed [31:0] div_round_sat(logic signed [127:0] num, int sh,
                                                        logic signed [127:0] den);
    logic [255:0] n, d, q, r;
    bit neg;
    neg = num[127] ^ den[127];
    n = 256'(num[127] ? -num : num) << sh;
    d = 256'(den[127] ? -den : den);
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    if (neg) begin
      if (q >= 256'h8000_0000) return 32'sh8000_0000;
      return -$signed(q[31:0]);
    end
    if (q > 256'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return $signed(q[31:0]);
  endfunction

  function automatic out_item_t invert_affine(in_item_t m);
    logic signed [127:0] a[3][3], t[3], adj[3][3], det, acc;
    logic signed [31:0] o[12];
    out_item_t r;
    a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
    a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
    a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
    t[0] = m.tx; t[1] = m.ty; t[2] = m.tz;
    // adj[j][k]: element j of adjugate column k (cross products of rows)
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        adj[j][k] = a[(k+1)%3][(j+1)%3] * a[(k+2)%3][(j+2)%3]
                  - a[(k+1)%3][(j+2)%3] * a[(k+2)%3][(j+1)%3];
      end
    end
    det = a[0][0] * adj[0][0] + a[0][1] * adj[1][0] + a[0][2] * adj[2][0];
    if (det == 0) return '0;
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        o[j*3+k] = div_round_sat(adj[j][k], 2 * Frac, det);
        acc = acc + adj[j][k] * t[k];
      end
      o[9+j] = div_round_sat(-acc, Frac, det);
    end
    r = {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], o[9], o[10], o[11]};
    return r;
  endfunction

  function automatic logic [31:0] rand_elem(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 << Frac)) - (4 << Frac));
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0001_0000;
          3: return 32'hFFFF_0000;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t rand_matrix();
    in_item_t m;
    logic [31:0] e[12];
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 12; i++) e[i] = rand_elem($urandom_range(0, 9) < 7 ? mode : 0);
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], e[9], e[10], e[11]};
    // make a share singular by repeating a row
    if ($urandom_range(0, 9) == 0) begin
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
    end
    return m;
  endfunction

  // driver: one transfer per accepted edge, inputs move at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took) void'(pending_q.pop_front());
      if (pending_q.size() > 0 && !hold_off && $urandom_range(0, 99) >= gap_pct) begin
        start  <= 1'b1;
        item_i <= pending_q[0];
      end else begin
        start  <= 1'b0;
        item_i <= rand_matrix();
      end
    end
  end

  // the prediction is queued on the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took <= start && !busy;
      if ((start && !busy) || strobe_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        inverse_q.push_back(invert_affine(item_i));
      end
      if (strobe_o) begin
        if (inverse_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", res_o);
        end else if (res_o !== inverse_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", inverse_q[0], res_o);
          void'(inverse_q.pop_front());
        end else begin
          void'(inverse_q.pop_front());
        end
      end
      if (idle_cycles >= IdleLimit && (!stim_done || inverse_q.size() > 0)) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_and_drain(int count);
    for (int i = 0; i < count; i++) pending_q.push_back(rand_matrix());
    wait (pending_q.size() == 0);
    wait (inverse_q.size() == 0);
  endtask

  initial begin
    in_item_t m;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: identity, scale, translation, singular, extremes
    m = '0; m.a00 = 1 << Frac; m.a11 = 1 << Frac; m.a22 = 1 << Frac;
    pending_q.push_back(m);
    m.tx = 32'h7FFF_FFFF; m.ty = 32'h8000_0000; m.tz = 3 << Frac;
    pending_q.push_back(m);
    m.a00 = 2 << Frac; m.a11 = -(4 << Frac); m.a22 = 1;
    pending_q.push_back(m);
    m = '0;
    pending_q.push_back(m);
    m = {12{32'h8000_0000}};
    pending_q.push_back(m);
    m = {12{32'h7FFF_FFFF}};
    pending_q.push_back(m);
    m = '0; m.a00 = 32'h8000_0000; m.a11 = 32'h7FFF_FFFF; m.a22 = 32'h8000_0000;
    pending_q.push_back(m);
    m = '0; m.a00 = 1; m.a11 = 1; m.a22 = 1; m.tx = 32'h8000_0000;
    pending_q.push_back(m);
    m = '0; m.a01 = 3; m.a12 = 3; m.a20 = 3; m.ty = -1;   // rounding, 1/3 style
    pending_q.push_back(m);
    m = '0; m.a02 = 2; m.a11 = 2; m.a20 = 2; m.tz = 1;
    pending_q.push_back(m);
    m = {32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    pending_q.push_back(m);
    wait (pending_q.size() == 0);
    wait (inverse_q.size() == 0);

    gap_pct = 37;
    send_and_drain(600);
    gap_pct = 55;
    send_and_drain(600);
    gap_pct = 0;
    send_and_drain(200);
    hold_off = 1'b1;                 // pause until everything has come back
    send_and_drain(0);
    hold_off = 1'b0;
    send_and_drain(450);

    stim_done = 1'b1;
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/aminv_pkg.sv
hw/rtl/aminv_front.sv
hw/rtl/aminv_fifo.sv
hw/rtl/aminv_back.sv
hw/rtl/affine_matrix_inverse.sv
verif/affine_matrix_inverse_tb.sv
